>>> sv/avs_pkg.sv
// Shared types, constants and lookup functions for the voltmeter display scanner.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package avs_pkg;

	localparam int unsigned SAMPLE_W    = 10;
	localparam int unsigned VALUE_W     = 13;
	localparam int unsigned IDX_W       = 2;
	localparam int unsigned DIGIT_COUNT_DEF = 4;
	localparam int unsigned FRAC_W      = 26;
	localparam int unsigned RECIP_W     = 23;
	localparam int unsigned MV_SCALE    = 625;
	localparam int unsigned MV_SHIFT    = 7;

	localparam logic [7:0] DP_MASK     = 8'b1000_0000;
	localparam logic [7:0] ANODE_FIRST = 8'b1000_0000;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_TICK   = 2'd1,
		FUNC_ENABLE = 2'd2,
		FUNC_MODE   = 2'd3
	} func_t;

	localparam logic [1:0] MODE_BLANK = 2'd0;
	localparam logic [1:0] MODE_RAW   = 2'd1;
	localparam logic [1:0] MODE_MV    = 2'd2;

	// one request as it leaves the state stage
	typedef struct packed {
		logic               tick;
		logic               blank;
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   idx;
		logic               led;
		logic [1:0]         mode;
	} scan_req_t;

	// ceil(2^FRAC_W / 10^(idx+1)); the fraction of value*recip holds the wanted digit
	function automatic logic [RECIP_W-1:0] digit_recip(input logic [IDX_W-1:0] idx);
		logic [RECIP_W-1:0] r;
		case (idx)
			2'd0:    r = 23'd6710887;
			2'd1:    r = 23'd671089;
			2'd2:    r = 23'd67109;
			default: r = 23'd6711;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] seg_decode(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0:    s = 7'b1011111;
			4'd1:    s = 7'b0000110;
			4'd2:    s = 7'b0111011;
			4'd3:    s = 7'b0101111;
			4'd4:    s = 7'b1100110;
			4'd5:    s = 7'b1101101;
			4'd6:    s = 7'b1111101;
			4'd7:    s = 7'b0000111;
			4'd8:    s = 7'b1111111;
			4'd9:    s = 7'b1101111;
			default: s = 7'b0000000;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> sv/adc_voltmeter_seven_segment_scan.sv
// Voltmeter seven-segment scanner, top level.
// Input channel (in_valid/in_ready): one request per accepted beat, func selects
// a sample load, a scan tick, an enable toggle or a mode step; sample is used on
// loads only and is held as zero while disabled.
// Output channel (out_valid/out_ready): exactly one result per request, carrying
// the segment and anode latches, the green status LED and the display mode as
// they stand after that request.
// Pipeline: input register, then the state and scaling stage with the millivolt
// multiplier, then the digit stage with the reciprocal multiplier feeding the
// result register.
// Throughput: one request per cycle; the pipeline moves as a whole whenever the
// result register is empty or being taken.
// A stall on out_ready holds every stage and drops in_ready in the same cycle.
// Reset (arst_n low) clears the held sample, enable, mode, scan index and both
// latches; the display starts blank, LED red.
// Depends on avs_pkg, avs_ctrl and avs_digit.
`default_nettype none

module adc_voltmeter_seven_segment_scan #(
	parameter int unsigned DIGIT_COUNT = avs_pkg::DIGIT_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    func,
	input  wire logic [avs_pkg::SAMPLE_W-1:0]  sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         segments,
	output logic [7:0]                         anode_select,
	output logic                               led_green,
	output logic [1:0]                         display_mode
);

	logic               adv;
	logic               valid_s2;
	avs_pkg::scan_req_t req_s2;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	avs_ctrl #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.func     (func),
		.sample   (sample),
		.req_s2   (req_s2),
		.valid_s2 (valid_s2)
	);

	avs_digit u_digit (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.valid_s2     (valid_s2),
		.req_s2       (req_s2),
		.valid_s3     (out_valid),
		.segments     (segments),
		.anode_select (anode_select),
		.led_green    (led_green),
		.display_mode (display_mode)
	);

endmodule

`default_nettype wire

>>> sv/avs_ctrl.sv
// Input register and state stage: held sample, enable, mode and scan index.
// Scales the shown value and hands one scan request per item to the digit stage.
// Depends on avs_pkg.
`default_nettype none

module avs_ctrl #(
	parameter int unsigned DIGIT_COUNT = avs_pkg::DIGIT_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           in_valid,
	input  wire logic [1:0]                     func,
	input  wire logic [avs_pkg::SAMPLE_W-1:0]   sample,
	output avs_pkg::scan_req_t                  req_s2,
	output logic                                valid_s2
);

	localparam logic [avs_pkg::IDX_W-1:0] IDX_LAST =
		avs_pkg::IDX_W'(DIGIT_COUNT - 1);

	logic                           valid_s1;
	logic [1:0]                     func_s1;
	logic [avs_pkg::SAMPLE_W-1:0]   sample_s1;

	logic [avs_pkg::SAMPLE_W-1:0]   held_q;
	logic                           enabled_q;
	logic [1:0]                     mode_q;
	logic [avs_pkg::IDX_W-1:0]      idx_q;

	logic [avs_pkg::SAMPLE_W-1:0]   held_d;
	logic                           enabled_d;
	logic [1:0]                     mode_d;
	logic [avs_pkg::IDX_W-1:0]      idx_d;
	logic                           tick;
	logic                           blank;
	logic [19:0]                    scaled;
	logic [avs_pkg::VALUE_W-1:0]    value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1   <= func;
			sample_s1 <= sample;
		end
	end

	always_comb begin
		held_d    = held_q;
		enabled_d = enabled_q;
		mode_d    = mode_q;
		idx_d     = idx_q;
		tick      = 1'b0;
		blank     = (mode_q == avs_pkg::MODE_BLANK);
		unique case (avs_pkg::func_t'(func_s1))
			avs_pkg::FUNC_SAMPLE: begin
				held_d = enabled_q ? sample_s1 : '0;
			end
			avs_pkg::FUNC_TICK: begin
				tick = 1'b1;
				if (!blank) begin
					idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
				end
			end
			avs_pkg::FUNC_ENABLE: begin
				enabled_d = ~enabled_q;
			end
			avs_pkg::FUNC_MODE: begin
				mode_d = (mode_q == avs_pkg::MODE_MV || mode_q == 2'd3) ?
					avs_pkg::MODE_BLANK : mode_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign scaled = 20'(held_q) * 20'(avs_pkg::MV_SCALE);
	assign value  = (mode_q == avs_pkg::MODE_MV) ?
		scaled[avs_pkg::MV_SHIFT +: avs_pkg::VALUE_W] : avs_pkg::VALUE_W'(held_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			enabled_q <= 1'b0;
			mode_q    <= avs_pkg::MODE_BLANK;
			idx_q     <= '0;
			valid_s2  <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				held_q    <= held_d;
				enabled_q <= enabled_d;
				mode_q    <= mode_d;
				idx_q     <= idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2.tick  <= tick;
			req_s2.blank <= blank;
			req_s2.value <= value;
			req_s2.idx   <= idx_q;
			req_s2.led   <= enabled_d;
			req_s2.mode  <= mode_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("mode register reached an unused code");
`endif

endmodule

`default_nettype wire

>>> sv/avs_digit.sv
// Digit stage and result register: extracts one decimal digit, decodes segments,
// selects the anode and holds the display latches. Depends on avs_pkg.
`default_nettype none

module avs_digit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 valid_s2,
	input  wire avs_pkg::scan_req_t   req_s2,
	output logic                      valid_s3,
	output logic [7:0]                segments,
	output logic [7:0]                anode_select,
	output logic                      led_green,
	output logic [1:0]                display_mode
);

	logic [35:0]                  prod;
	logic [avs_pkg::FRAC_W-1:0]   frac;
	logic [29:0]                  frac10;
	logic [3:0]                   digit;
	logic [7:0]                   seg_d;
	logic [7:0]                   anode_d;

	logic [7:0] seg_q;
	logic [7:0] anode_q;
	logic       led_q;
	logic [1:0] mode_q;

	assign prod    = 36'(req_s2.value) * 36'(avs_pkg::digit_recip(req_s2.idx));
	assign frac    = prod[avs_pkg::FRAC_W-1:0];
	assign frac10  = 30'({frac, 3'b000}) + 30'({frac, 1'b0});
	assign digit   = frac10[29:avs_pkg::FRAC_W];
	assign anode_d = avs_pkg::ANODE_FIRST >> req_s2.idx;
	assign seg_d   = {(req_s2.idx == 2'd1), avs_pkg::seg_decode(digit)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			seg_q    <= '0;
			anode_q  <= '0;
			led_q    <= 1'b0;
			mode_q   <= avs_pkg::MODE_BLANK;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				led_q  <= req_s2.led;
				mode_q <= req_s2.mode;
				if (req_s2.tick) begin
					seg_q   <= req_s2.blank ? 8'h00 : seg_d;
					anode_q <= req_s2.blank ? 8'h00 : anode_d;
				end
			end
		end
	end

	assign segments     = seg_q;
	assign anode_select = anode_q;
	assign led_green    = led_q;
	assign display_mode = mode_q;

`ifndef NO_ASSERTIONS
	a_anode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(anode_q) && (anode_q[3:0] == 4'h0))
		else $error("anode select not one-hot in upper nibble");

	a_dp_digit: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q[7] == (anode_q == 8'h40))
		else $error("decimal point lit on wrong digit");

	a_blank_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(anode_q == 8'h00) == (seg_q == 8'h00))
		else $error("segments and anode disagree on blank");
`endif

endmodule

`default_nettype wire

>>> dv/adc_voltmeter_seven_segment_scan_tb.sv
// Testbench for adc_voltmeter_seven_segment_scan: directed and random event requests,
// a scoreboard class that tracks the display state and checks every result in order.
// Depends on avs_pkg and the block's RTL.
`timescale 1ns / 100ps

module adc_voltmeter_seven_segment_scan_tb;

	localparam int unsigned DIGITS       = avs_pkg::DIGIT_COUNT_DEF;
	localparam int unsigned RANDOM_ITEMS = 1730;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [7:0] seg;
		logic [7:0] an;
		logic       led;
		logic [1:0] mode;
	} display_word_t;

	class scan_scoreboard;
		logic [avs_pkg::SAMPLE_W-1:0] held;
		logic                         enabled;
		logic [1:0]                   mode;
		logic [1:0]                   digit_idx;
		logic [7:0]                   seg_latch;
		logic [7:0]                   anode_latch;
		display_word_t                pending[$];
		int unsigned                  mismatches;
		int unsigned                  checked;

		function new();
			held        = '0;
			enabled     = 1'b0;
			mode        = avs_pkg::MODE_BLANK;
			digit_idx   = '0;
			seg_latch   = '0;
			anode_latch = '0;
			mismatches  = 0;
			checked     = 0;
		endfunction

		function logic [6:0] glyph(input int unsigned d);
			case (d)
				0:       return 7'h5F;
				1:       return 7'h06;
				2:       return 7'h3B;
				3:       return 7'h2F;
				4:       return 7'h66;
				5:       return 7'h6D;
				6:       return 7'h7D;
				7:       return 7'h07;
				8:       return 7'h7F;
				default: return 7'h6F;
			endcase
		endfunction

		function void scan_digit();
			int unsigned value;
			int unsigned k;
			seg_latch   = '0;
			anode_latch = '0;
			if (mode == avs_pkg::MODE_BLANK)
				return;
			value = held;
			if (mode == avs_pkg::MODE_MV)
				value = (value * avs_pkg::MV_SCALE) >> avs_pkg::MV_SHIFT;
			for (k = 0; k < digit_idx; k++)
				value = value / 10;
			seg_latch   = {1'b0, glyph(value % 10)};
			anode_latch = avs_pkg::ANODE_FIRST >> digit_idx;
			if (digit_idx == 2'd1)
				seg_latch = seg_latch | avs_pkg::DP_MASK;
			digit_idx = 2'((digit_idx + 1) % DIGITS);
		endfunction

		function void note_request(input avs_pkg::func_t f,
				input logic [avs_pkg::SAMPLE_W-1:0] s);
			display_word_t w;
			case (f)
				avs_pkg::FUNC_SAMPLE: held = enabled ? s : '0;
				avs_pkg::FUNC_TICK:   scan_digit();
				avs_pkg::FUNC_ENABLE: enabled = ~enabled;
				default: mode = (mode >= avs_pkg::MODE_MV) ? avs_pkg::MODE_BLANK :
					mode + 2'd1;
			endcase
			w.seg  = seg_latch;
			w.an   = anode_latch;
			w.led  = enabled;
			w.mode = mode;
			pending.push_back(w);
		endfunction

		task report(input string what, input int unsigned got, input int unsigned want);
			mismatches++;
			$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		endtask

		task check_result(input logic [7:0] seg, input logic [7:0] an, input logic led,
				input logic [1:0] md);
			display_word_t w;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected result", {seg, an}, 0);
				return;
			end
			w = pending.pop_front();
			if (seg !== w.seg)
				report("segments", seg, w.seg);
			if (an !== w.an)
				report("anode_select", an, w.an);
			if (led !== w.led)
				report("led_green", led, w.led);
			if (md !== w.mode)
				report("display_mode", md, w.mode);
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [1:0]                   func = avs_pkg::FUNC_SAMPLE;
	logic [avs_pkg::SAMPLE_W-1:0] sample = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [7:0]                   segments;
	logic [7:0]                   anode_select;
	logic                         led_green;
	logic [1:0]                   display_mode;

	logic        steady = 1'b0;
	int unsigned cycles = 0;

	scan_scoreboard sb = new();

	adc_voltmeter_seven_segment_scan #(.DIGIT_COUNT(DIGITS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.segments     (segments),
		.anode_select (anode_select),
		.led_green    (led_green),
		.display_mode (display_mode)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic avs_pkg::func_t pick_func();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return avs_pkg::FUNC_TICK;
		if (r < 70)
			return avs_pkg::FUNC_SAMPLE;
		if (r < 82)
			return avs_pkg::FUNC_ENABLE;
		return avs_pkg::FUNC_MODE;
	endfunction

	function automatic logic [avs_pkg::SAMPLE_W-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return avs_pkg::SAMPLE_W'($urandom());
	endfunction

	// entered just after a rising edge; returns just after the edge that takes the request
	task send_request(input avs_pkg::func_t f, input logic [avs_pkg::SAMPLE_W-1:0] s);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			func     <= 2'($urandom());
			sample   <= avs_pkg::SAMPLE_W'($urandom());
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		func     <= f;
		sample   <= s;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(f, s);
	endtask

	initial begin
		int unsigned n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(avs_pkg::FUNC_SAMPLE, '1);
		send_request(avs_pkg::FUNC_TICK, '0);
		send_request(avs_pkg::FUNC_MODE, '0);
		send_request(avs_pkg::FUNC_TICK, '1);
		send_request(avs_pkg::FUNC_ENABLE, '0);
		send_request(avs_pkg::FUNC_SAMPLE, '1);
		repeat (4) send_request(avs_pkg::FUNC_TICK, '0);
		send_request(avs_pkg::FUNC_MODE, '1);
		repeat (4) send_request(avs_pkg::FUNC_TICK, '0);
		send_request(avs_pkg::FUNC_SAMPLE, '0);
		send_request(avs_pkg::FUNC_TICK, '1);
		send_request(avs_pkg::FUNC_MODE, '0);
		send_request(avs_pkg::FUNC_TICK, '0);
		send_request(avs_pkg::FUNC_ENABLE, '1);
		send_request(avs_pkg::FUNC_SAMPLE, 10'd517);
		send_request(avs_pkg::FUNC_MODE, '0);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 800 && n < 1000);
			send_request(pick_func(), pick_sample());
		end
		steady = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// receiver: random stalls, one long hold-off to back up the pipeline
	initial begin
		int unsigned stall_left;
		bit          held_off;
		stall_left = 0;
		held_off   = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sb.checked >= 300) begin
				held_off   = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(segments, anode_select, led_green, display_mode);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule
